FILE: design/zhpd_pkg.sv
package zhpd_pkg;

    // Fixed field widths
    localparam int KW       = 13;
    localparam int DelayW   = 32;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 32;

    // Register indexes on the configuration channel
    localparam logic [CfgIdxW-1:0] REG_MEAN        = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_SIGMA       = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_K_ENTER     = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_K_LEAVE     = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_ENTER_DELAY = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_LEAVE_DELAY = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_CLEAR_HOLD  = 3'd6;

    // Reset values of the registers
    localparam int           MEAN_RST        = 0;
    localparam int           SIGMA_RST       = 256;
    localparam logic [KW-1:0] K_ENTER_RST    = 13'sd768;
    localparam logic [KW-1:0] K_LEAVE_RST    = 13'sd512;
    localparam logic [DelayW-1:0] ENTER_DELAY_RST = 32'd3000;
    localparam logic [DelayW-1:0] LEAVE_DELAY_RST = 32'd5000;
    localparam logic [DelayW-1:0] CLEAR_HOLD_RST  = 32'd30000;

    // Published phase codes
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_DEB_ON  = 2'd1;
    localparam logic [1:0] PH_PRESENT = 2'd2;
    localparam logic [1:0] PH_DEB_OFF = 2'd3;

    // Event codes
    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_ON   = 2'd1;
    localparam logic [1:0] EV_OFF  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_DEB_ON  = 4'b0010,
        ST_PRESENT = 4'b0100,
        ST_DEB_OFF = 4'b1000
    } state_t;

    // Relation of the z-score to one threshold
    typedef struct packed {
        logic gt;
        logic ge;
    } zrel_t;

    // Threshold flags for the state machine
    typedef struct packed {
        logic high;
        logic hit_strong;
        logic low;
    } zflags_t;

    // One result item
    typedef struct packed {
        logic [1:0] event_res;
        logic [1:0] phase;
        logic       present;
    } result_t;

    function automatic logic [1:0] phase_code(input state_t st);
        logic [1:0] code;
        case (st)
            ST_IDLE:    code = PH_IDLE;
            ST_DEB_ON:  code = PH_DEB_ON;
            ST_PRESENT: code = PH_PRESENT;
            ST_DEB_OFF: code = PH_DEB_OFF;
            default:    code = PH_IDLE;
        endcase
        return code;
    endfunction

endpackage

FILE: design/zhpd_zcmp.sv
module zhpd_zcmp #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int SIGMA_WIDTH  = 17
) (
    input  logic [SAMPLE_WIDTH-1:0]        energy,
    input  logic [SAMPLE_WIDTH-1:0]        mean,
    input  logic [SIGMA_WIDTH-1:0]         sigma,
    input  logic signed [zhpd_pkg::KW-1:0] k,
    output zhpd_pkg::zrel_t                rel
);

    localparam int CW = SIGMA_WIDTH + 15;
    localparam int PW = SIGMA_WIDTH + zhpd_pkg::KW + 1;

    logic signed [CW-1:0] energy_x;
    logic signed [CW-1:0] mean_x;
    logic signed [CW-1:0] diff;
    logic signed [CW-1:0] lhs;
    logic signed [CW-1:0] rhs;
    logic signed [CW-1:0] k_x;
    logic signed [CW-1:0] prod_x;
    logic signed [SIGMA_WIDTH:0] sigma_s;
    logic signed [PW-1:0] prod;
    logic                 sigma_zero;

    // Scale energy minus mean by 256 to line up with k times sigma
    assign energy_x = {{(CW-SAMPLE_WIDTH){1'b0}}, energy};
    assign mean_x   = {{(CW-SAMPLE_WIDTH){1'b0}}, mean};
    assign diff     = energy_x - mean_x;
    assign sigma_zero = (sigma == '0);

    // Threshold times sigma, one narrow signed multiply
    assign sigma_s = {1'b0, sigma};
    assign prod    = k * sigma_s;
    assign prod_x  = {{(CW-PW){prod[PW-1]}}, prod};
    assign k_x     = {{(CW-zhpd_pkg::KW){k[zhpd_pkg::KW-1]}}, k};

    // Zero sigma means z is exactly zero
    assign lhs = sigma_zero ? '0  : (diff <<< 8);
    assign rhs = sigma_zero ? k_x : prod_x;

    assign rel.gt = (lhs > rhs);
    assign rel.ge = (lhs >= rhs);

endmodule

FILE: design/zhpd_fsm.sv
module zhpd_fsm #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            step,
    input  zhpd_pkg::zflags_t               flags,
    input  logic [TIME_WIDTH-1:0]           now,
    input  logic [zhpd_pkg::DelayW-1:0]     enter_delay,
    input  logic [zhpd_pkg::DelayW-1:0]     leave_delay,
    input  logic [zhpd_pkg::DelayW-1:0]     clear_hold,
    output zhpd_pkg::result_t               res
);

    localparam int CmpW = (TIME_WIDTH > zhpd_pkg::DelayW) ? TIME_WIDTH : zhpd_pkg::DelayW;

    zhpd_pkg::state_t        state_reg, state_next;
    logic [TIME_WIDTH-1:0]   dstart_reg, dstart_next;
    logic [TIME_WIDTH-1:0]   lstrong_reg, lstrong_next;
    logic                    present_reg, present_next;
    logic [1:0]              event_code;

    logic [TIME_WIDTH-1:0]   el_deb;
    logic [TIME_WIDTH-1:0]   el_strong;
    logic                    enter_done;
    logic                    leave_done;
    logic                    hold_done;

    // Elapsed times wrap with the timestamp width
    assign el_deb    = now - dstart_reg;
    // A strong sample in the present phase restarts the hold right now
    assign el_strong = flags.hit_strong ? '0 : (now - lstrong_reg);

    assign enter_done = CmpW'(el_deb)    >= CmpW'(enter_delay);
    assign leave_done = CmpW'(el_deb)    >= CmpW'(leave_delay);
    assign hold_done  = CmpW'(el_strong) >= CmpW'(clear_hold);

    // Next state of the presence machine
    always_comb begin
        state_next   = state_reg;
        dstart_next  = dstart_reg;
        lstrong_next = lstrong_reg;
        present_next = present_reg;
        event_code   = zhpd_pkg::EV_NONE;
        case (state_reg)
            zhpd_pkg::ST_IDLE: begin
                if (flags.high) begin
                    dstart_next = now;
                    state_next  = zhpd_pkg::ST_DEB_ON;
                end
            end
            zhpd_pkg::ST_DEB_ON: begin
                if (flags.high) begin
                    if (enter_done) begin
                        state_next   = zhpd_pkg::ST_PRESENT;
                        lstrong_next = now;
                        present_next = 1'b1;
                        event_code   = zhpd_pkg::EV_ON;
                    end
                end else begin
                    state_next = zhpd_pkg::ST_IDLE;
                end
            end
            zhpd_pkg::ST_PRESENT: begin
                if (flags.hit_strong) begin
                    lstrong_next = now;
                end
                if (flags.low && hold_done) begin
                    dstart_next = now;
                    state_next  = zhpd_pkg::ST_DEB_OFF;
                end
            end
            zhpd_pkg::ST_DEB_OFF: begin
                if (flags.low) begin
                    if (leave_done) begin
                        state_next   = zhpd_pkg::ST_IDLE;
                        present_next = 1'b0;
                        event_code   = zhpd_pkg::EV_OFF;
                    end
                end else if (flags.high) begin
                    state_next   = zhpd_pkg::ST_PRESENT;
                    lstrong_next = now;
                end
            end
            default: begin
                state_next = zhpd_pkg::ST_IDLE;
            end
        endcase
    end

    // Commit the state when the request moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= zhpd_pkg::ST_IDLE;
            dstart_reg  <= '0;
            lstrong_reg <= '0;
            present_reg <= 1'b0;
        end else if (step) begin
            state_reg   <= state_next;
            dstart_reg  <= dstart_next;
            lstrong_reg <= lstrong_next;
            present_reg <= present_next;
        end
    end

    assign res.present   = present_next;
    assign res.phase     = zhpd_pkg::phase_code(state_next);
    assign res.event_res = event_code;

endmodule

FILE: design/zscore_hysteresis_presence_debounce.sv
// Presence detector: each request carries an energy sample and its millisecond
// timestamp and yields one result with the published presence, the phase after
// the step and an on or off event. The sample is compared with the baseline as
// a z-score without division, against the enter and leave thresholds, and a
// four-phase machine applies the debounce delays and the clear hold. One
// request is accepted every clock cycle while the result register is free or
// drains; its result goes through the input register, then the result
// register. The cycle time is set by the threshold multiply and compare
// feeding the state update. Configuration writes are always accepted and
// must be made while no request is in flight.
module zscore_hysteresis_presence_debounce #(
    parameter int TIME_WIDTH   = 32,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [zhpd_pkg::CfgIdxW-1:0]      cfg_index,
    input  logic [zhpd_pkg::CfgDataW-1:0]     cfg_data,
    // Sample requests
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // energy_sample, time_ms (from bit 0 up), zero padded
    input  logic [((SAMPLE_WIDTH+TIME_WIDTH+7)/8)*8-1:0] s_tdata,
    // Results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // present, phase, event_res (from bit 0 up), zero padded
    output logic [7:0]                        m_tdata
);

    localparam int SigW  = (SAMPLE_WIDTH > 9) ? SAMPLE_WIDTH : 9;
    localparam int ResW  = $bits(zhpd_pkg::result_t);

    // Configuration registers
    logic [SAMPLE_WIDTH-1:0]            mean_reg;
    logic [SigW-1:0]                    sigma_reg;
    logic signed [zhpd_pkg::KW-1:0]     k_enter_reg;
    logic signed [zhpd_pkg::KW-1:0]     k_leave_reg;
    logic [zhpd_pkg::DelayW-1:0]        enter_delay_reg;
    logic [zhpd_pkg::DelayW-1:0]        leave_delay_reg;
    logic [zhpd_pkg::DelayW-1:0]        clear_hold_reg;

    // Input stage
    logic                               in_valid_reg;
    logic [SAMPLE_WIDTH-1:0]            energy_reg;
    logic [TIME_WIDTH-1:0]              time_reg;

    // Result stage
    logic                               m_valid_reg;
    zhpd_pkg::result_t                  res_reg;
    zhpd_pkg::result_t                  res_next;

    logic                               advance;
    zhpd_pkg::zrel_t                    rel_enter;
    zhpd_pkg::zrel_t                    rel_leave;
    zhpd_pkg::zflags_t                  flags;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mean_reg        <= SAMPLE_WIDTH'(zhpd_pkg::MEAN_RST);
            sigma_reg       <= SigW'(zhpd_pkg::SIGMA_RST);
            k_enter_reg     <= zhpd_pkg::K_ENTER_RST;
            k_leave_reg     <= zhpd_pkg::K_LEAVE_RST;
            enter_delay_reg <= zhpd_pkg::ENTER_DELAY_RST;
            leave_delay_reg <= zhpd_pkg::LEAVE_DELAY_RST;
            clear_hold_reg  <= zhpd_pkg::CLEAR_HOLD_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                zhpd_pkg::REG_MEAN:        mean_reg <= cfg_data[SAMPLE_WIDTH-1:0];
                zhpd_pkg::REG_SIGMA:       sigma_reg <= SigW'(cfg_data[SAMPLE_WIDTH-1:0]);
                zhpd_pkg::REG_K_ENTER:     k_enter_reg <= cfg_data[zhpd_pkg::KW-1:0];
                zhpd_pkg::REG_K_LEAVE:     k_leave_reg <= cfg_data[zhpd_pkg::KW-1:0];
                zhpd_pkg::REG_ENTER_DELAY: enter_delay_reg <= cfg_data;
                zhpd_pkg::REG_LEAVE_DELAY: leave_delay_reg <= cfg_data;
                zhpd_pkg::REG_CLEAR_HOLD:  clear_hold_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Move a request forward when the result register is free or drains
    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Hold the accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            energy_reg <= s_tdata[SAMPLE_WIDTH-1:0];
            time_reg   <= s_tdata[SAMPLE_WIDTH +: TIME_WIDTH];
        end
    end

    // Compare the z-score with both thresholds
    zhpd_zcmp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .SIGMA_WIDTH  (SigW)
    ) u_cmp_enter (
        .energy (energy_reg),
        .mean   (mean_reg),
        .sigma  (sigma_reg),
        .k      (k_enter_reg),
        .rel    (rel_enter)
    );

    zhpd_zcmp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .SIGMA_WIDTH  (SigW)
    ) u_cmp_leave (
        .energy (energy_reg),
        .mean   (mean_reg),
        .sigma  (sigma_reg),
        .k      (k_leave_reg),
        .rel    (rel_leave)
    );

    assign flags.high       = rel_enter.ge;
    assign flags.hit_strong = rel_enter.gt;
    assign flags.low        = !rel_leave.ge;

    zhpd_fsm #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_fsm (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .flags       (flags),
        .now         (time_reg),
        .enter_delay (enter_delay_reg),
        .leave_delay (leave_delay_reg),
        .clear_hold  (clear_hold_reg),
        .res         (res_next)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(8-ResW){1'b0}}, res_reg};

`ifndef SYNTHESIS
    // Presence is published exactly in the present and debouncing-off phases
    a_present_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res_reg.present ==
            (res_reg.phase == zhpd_pkg::PH_PRESENT || res_reg.phase == zhpd_pkg::PH_DEB_OFF)))
        else $error("present flag disagrees with phase");

    // An on event lands in the present phase
    a_event_on: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_reg.event_res == zhpd_pkg::EV_ON) |->
            (res_reg.phase == zhpd_pkg::PH_PRESENT && res_reg.present))
        else $error("on event without presence");

    // An off event lands in idle
    a_event_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_reg.event_res == zhpd_pkg::EV_OFF) |->
            (res_reg.phase == zhpd_pkg::PH_IDLE && !res_reg.present))
        else $error("off event without clearing");

    // A waiting request moves on as soon as the result register frees up
    a_no_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && (!m_valid_reg || m_tready)) |=> m_tvalid)
        else $error("request stalled with a free result register");
`endif

endmodule
